@@ hw/rtl/etrt_pkg.sv @@
`default_nettype none
package etrt_pkg;

  localparam int TW = 40;
  localparam int RW = 16;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  localparam logic [1:0] REG_DUR  = 2'd0;
  localparam logic [1:0] REG_TIN  = 2'd1;
  localparam logic [1:0] REG_TOUT = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIECE,
    ST_DIV,
    ST_COMMIT,
    ST_SCAN,
    ST_FDIV,
    ST_ADIV,
    ST_BMUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start_load;
    logic load_second;
    logic piece_setup;
    logic div_start;
    logic commit;
    logic finish_load;
    logic start_query;
    logic scan_step;
    logic fdiv_setup;
    logic adiv_setup;
    logic back_calc;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic need_first;
    logic need_second;
    logic piece_keep;
    logic div_busy;
    logic scan_done;
    logic fwd_need_div;
    logic aft_need_div;
  } sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/etrt_if.sv @@
`default_nettype none
interface etrt_in_if;
  import etrt_pkg::*;
  logic          valid;
  logic          ready;
  logic          command;
  logic [TW-1:0] frag_start;
  logic          frag_removed;
  logic [RW-1:0] frag_speed;
  logic          frag_last;
  logic [TW-1:0] query_source_time;
  logic [TW-1:0] query_output_time;
  modport source(output valid, command, frag_start, frag_removed, frag_speed, frag_last,
                 query_source_time, query_output_time, input ready);
  modport sink(input valid, command, frag_start, frag_removed, frag_speed, frag_last,
               query_source_time, query_output_time, output ready);
endinterface

interface etrt_out_if;
  import etrt_pkg::*;
  logic          valid;
  logic          ready;
  logic          forward_valid;
  logic [TW-1:0] forward_time;
  logic [TW-1:0] forward_after_time;
  logic [TW-1:0] backward_time;
  modport source(output valid, forward_valid, forward_time, forward_after_time,
                 backward_time, input ready);
  modport sink(input valid, forward_valid, forward_time, forward_after_time,
               backward_time, output ready);
endinterface

interface etrt_cfg_if;
  import etrt_pkg::*;
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  logic [TW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/etrt_div.sv @@
`default_nettype none
module etrt_div
  import etrt_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [TW-1:0] delta,
  input  wire logic [RW-1:0] rate,
  output logic               busy,
  output logic [TW+7:0]      quot
);
  localparam int NW = TW + 8;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [RW:0]   rem_r, rem_nxt;
  logic [RW-1:0] d_r, d_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [RW:0]   sh;
  logic [RW:0]   diff;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    sh = {rem_r[RW-1:0], q_r[NW-1]};
    diff = sh - {1'b0, d_r};
    if (start) begin
      q_nxt = {delta, 8'd0};
      rem_nxt = '0;
      d_nxt = (rate == '0) ? RW'(1) : rate;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[RW]) begin
        rem_nxt = diff;
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule
`default_nettype wire

@@ hw/rtl/etrt_ctrl.sv @@
`default_nettype none
module etrt_ctrl
  import etrt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic in_cmd,
  input  wire logic out_taken,
  input  wire sts_t sts,
  output logic      in_ready,
  output logic      out_valid,
  output ctl_t      ctl
);
  state_t state_r, state_nxt;
  logic   second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      second_r <= second_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    second_nxt = second_r;
    ctl = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_cmd == CMD_LOAD) begin
            ctl.start_load = 1'b1;
            second_nxt = 1'b0;
            state_nxt = ST_PIECE;
          end else begin
            ctl.start_query = 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_PIECE: begin
        if (!second_r && !sts.need_first) begin
          second_nxt = 1'b1;
        end else if (second_r && !sts.need_second) begin
          ctl.finish_load = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.piece_setup = 1'b1;
          ctl.load_second = second_r;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        ctl.load_second = second_r;
        if (!sts.piece_keep) begin
          state_nxt = ST_COMMIT;
        end else begin
          ctl.div_start = 1'b1;
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        ctl.load_second = second_r;
        if (!sts.div_busy) begin
          ctl.commit = sts.piece_keep;
          second_nxt = 1'b1;
          if (second_r) begin
            ctl.finish_load = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PIECE;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          ctl.fdiv_setup = sts.fwd_need_div;
          ctl.div_start = sts.fwd_need_div;
          state_nxt = ST_FDIV;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_FDIV: begin
        if (!sts.div_busy) begin
          ctl.adiv_setup = 1'b1;
          ctl.div_start = sts.aft_need_div;
          state_nxt = ST_ADIV;
        end
      end
      ST_ADIV: begin
        if (!sts.div_busy) begin
          ctl.back_calc = 1'b1;
          state_nxt = ST_BMUL;
        end
      end
      ST_BMUL: begin
        ctl.out_load = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_taken) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/etrt_dp.sv @@
`default_nettype none
module etrt_dp
  import etrt_pkg::*;
#(
  parameter int MAX_PIECES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ctl_t          ctl,
  output sts_t               sts,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [TW-1:0] cfg_val,
  input  wire logic          i_removed,
  input  wire logic [TW-1:0] i_start,
  input  wire logic [RW-1:0] i_speed,
  input  wire logic          i_last,
  input  wire logic [TW-1:0] i_src,
  input  wire logic [TW-1:0] i_out,
  output logic               o_fvalid,
  output logic [TW-1:0]      o_ftime,
  output logic [TW-1:0]      o_atime,
  output logic [TW-1:0]      o_btime
);
  localparam int AW = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
  localparam int CW = $clog2(MAX_PIECES + 1);
  localparam int EW = TW + RW + 8;

  logic [TW-1:0] dur_r, tin_r, tout_r;
  logic [TW-1:0] mem_ss [MAX_PIECES];
  logic [TW-1:0] mem_se [MAX_PIECES];
  logic [TW-1:0] mem_os [MAX_PIECES];
  logic [RW-1:0] mem_rt [MAX_PIECES];

  logic [CW-1:0] cnt_r;
  logic [TW-1:0] oend_r;
  logic [TW-1:0] hs_r;
  logic          hrm_r;
  logic [RW-1:0] hrt_r;
  logic          hv_r;

  logic [TW-1:0] ls_r;
  logic          lrm_r, llast_r;
  logic [RW-1:0] lrt_r;
  logic [TW-1:0] qs_r;

  logic [TW-1:0] ps_r, pe_r;
  logic [RW-1:0] pr_r;
  logic          pk_r;

  logic          div_start, div_busy;
  logic [TW-1:0] div_delta;
  logic [RW-1:0] div_rate;
  logic [TW+7:0] div_q;

  etrt_div u_div (
    .clk, .rst_n, .start(div_start), .delta(div_delta), .rate(div_rate),
    .busy(div_busy), .quot(div_q)
  );

  // scan state
  logic [CW-1:0] si_r;
  logic          rd_v_r;
  logic [TW-1:0] rss_r, rse_r, ros_r;
  logic [RW-1:0] rrt_r;
  logic [CW-1:0] ri_r;
  logic          fv_r, fdone_r, adone_r, aneed_r;
  logic [TW-1:0] fss_r, fos_r, ass_r, aos_r, aval_r;
  logic [RW-1:0] frt_r, art_r;
  logic [TW-1:0] bss_r, bse_r, bos_r, tq_r;
  logic [RW-1:0] brt_r;
  logic [TW-1:0] fres_r;
  logic [EW-1:0] bprod_r;

  logic [TW-1:0] lo, hi, fs, fe, s_c, e_c;
  logic          rm_c;
  logic [RW-1:0] rt_c;

  always_comb begin
    lo = (tin_r < dur_r) ? tin_r : dur_r;
    hi = (tout_r < lo) ? lo : ((tout_r > dur_r) ? dur_r : tout_r);
    if (!ctl.load_second) begin
      fs = hs_r; fe = ls_r; rm_c = hrm_r; rt_c = hrt_r;
    end else begin
      fs = ls_r; fe = dur_r; rm_c = lrm_r; rt_c = lrt_r;
    end
    s_c = (fs > lo) ? fs : lo;
    e_c = (fe < hi) ? fe : hi;
  end

  function automatic logic [TW-1:0] sat(input logic [TW-1:0] a, input logic [TW+7:0] b);
    logic [TW+8:0] s;
    s = {9'd0, a} + {1'b0, b};
    return (s > {9'd0, TMAX}) ? TMAX : s[TW-1:0];
  endfunction

  assign sts.need_first = hv_r;
  assign sts.need_second = llast_r;
  assign sts.piece_keep = pk_r;
  assign sts.div_busy = div_busy;
  assign sts.scan_done = (si_r >= cnt_r) && !rd_v_r;
  assign sts.fwd_need_div = fv_r;
  assign sts.aft_need_div = aneed_r;

  always_comb begin
    div_start = ctl.div_start;
    div_delta = pe_r - ps_r;
    div_rate = pr_r;
    if (ctl.fdiv_setup) begin
      div_delta = qs_r - fss_r; div_rate = frt_r;
    end else if (ctl.adiv_setup) begin
      div_delta = qs_r - ass_r; div_rate = art_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= '0; tin_r <= '0; tout_r <= '0;
      cnt_r <= '0; oend_r <= '0;
      hs_r <= '0; hrm_r <= 1'b0; hrt_r <= '0; hv_r <= 1'b0;
      llast_r <= 1'b0; rd_v_r <= 1'b0; si_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_DUR:  dur_r <= cfg_val;
          REG_TIN:  tin_r <= cfg_val;
          REG_TOUT: tout_r <= cfg_val;
          default: ;
        endcase
      end
      if (ctl.start_load) begin
        llast_r <= i_last;
        if (!hv_r) begin
          cnt_r <= '0; oend_r <= '0;
        end
      end
      if (ctl.commit) begin
        cnt_r <= cnt_r + CW'(1);
        oend_r <= sat(oend_r, div_q);
      end
      if (ctl.finish_load) begin
        if (llast_r) hv_r <= 1'b0;
        else begin
          hv_r <= 1'b1; hs_r <= ls_r; hrm_r <= lrm_r; hrt_r <= lrt_r;
        end
      end
      if (ctl.start_query) begin
        si_r <= '0; rd_v_r <= 1'b0;
      end else if (ctl.scan_step) begin
        rd_v_r <= (si_r < cnt_r);
        if (si_r < cnt_r) si_r <= si_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start_load) begin
      ls_r <= i_start; lrm_r <= i_removed; lrt_r <= i_speed;
    end
    if (ctl.piece_setup) begin
      ps_r <= s_c; pe_r <= e_c; pr_r <= (rt_c == '0) ? RW'(1) : rt_c;
      pk_r <= !rm_c && (e_c > s_c) && (cnt_r < CW'(MAX_PIECES));
    end
    if (ctl.commit) begin
      mem_ss[cnt_r[AW-1:0]] <= ps_r;
      mem_se[cnt_r[AW-1:0]] <= pe_r;
      mem_os[cnt_r[AW-1:0]] <= oend_r;
      mem_rt[cnt_r[AW-1:0]] <= pr_r;
    end
    ri_r <= si_r;
    rss_r <= mem_ss[si_r[AW-1:0]];
    rse_r <= mem_se[si_r[AW-1:0]];
    ros_r <= mem_os[si_r[AW-1:0]];
    rrt_r <= mem_rt[si_r[AW-1:0]];
    if (ctl.start_query) begin
      qs_r <= i_src;
      tq_r <= (i_out < oend_r) ? i_out : oend_r;
      fv_r <= 1'b0; fdone_r <= 1'b0; adone_r <= 1'b0; aneed_r <= 1'b0;
      aval_r <= oend_r;
      bss_r <= '0; bse_r <= '0; bos_r <= '0; brt_r <= '0;
    end else if (rd_v_r && ctl.scan_step) begin
      if (!fdone_r && qs_r >= rss_r &&
          (qs_r < rse_r || (ri_r + CW'(1) == cnt_r && qs_r == rse_r))) begin
        fdone_r <= 1'b1; fv_r <= 1'b1;
        fss_r <= rss_r; fos_r <= ros_r; frt_r <= rrt_r;
      end
      if (!adone_r) begin
        if (qs_r < rss_r) begin
          adone_r <= 1'b1; aval_r <= ros_r;
        end else if (qs_r < rse_r) begin
          adone_r <= 1'b1; aneed_r <= 1'b1;
          ass_r <= rss_r; aos_r <= ros_r; art_r <= rrt_r;
        end
      end
      if (ri_r == '0 || ros_r <= tq_r) begin
        bss_r <= rss_r; bse_r <= rse_r; bos_r <= ros_r; brt_r <= rrt_r;
      end
    end
    if (ctl.adiv_setup) fres_r <= fv_r ? sat(fos_r, div_q) : '0;
    if (ctl.back_calc) begin
      bprod_r <= EW'((tq_r >= bos_r) ? (tq_r - bos_r) : '0) * EW'(brt_r);
    end
    if (ctl.out_load) begin
      o_fvalid <= fv_r;
      o_ftime <= fres_r;
      o_atime <= aneed_r ? sat(aos_r, div_q) : aval_r;
      if (cnt_r == '0) o_btime <= '0;
      else begin
        o_btime <= ({24'd0, bss_r} + bprod_r[EW-1:8] < {24'd0, bse_r}) ?
                   TW'({24'd0, bss_r} + bprod_r[EW-1:8]) : bse_r;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/edit_time_remap_table.sv @@
// Channel | Dir | Payload
// in_     | in  | command, fragment fields, query times
// out_    | out | forward_valid, forward_time, forward_after_time, backward_time
// cfg_    | in  | index (0..2), 40-bit data
// A load handles up to two pieces after accept, each kept piece with a 48-step divide.
// Queries scan the stored pieces, then run up to two divides (forward, after) and a multiply.
// rst_n is synchronous; out_valid holds until out_ready, input stalls meanwhile.
`default_nettype none
module edit_time_remap_table
  import etrt_pkg::*;
#(
  parameter int MAX_PIECES = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  etrt_in_if.sink   in_ch,
  etrt_out_if.source out_ch,
  etrt_cfg_if.sink  cfg_ch
);
  ctl_t ctl;
  sts_t sts;
  logic in_ready, out_valid;

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

  etrt_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_ch.valid && in_ready),
    .in_cmd(in_ch.command),
    .out_taken(out_ch.ready),
    .sts, .in_ready, .out_valid, .ctl
  );

  etrt_dp #(.MAX_PIECES(MAX_PIECES)) u_dp (
    .clk, .rst_n, .ctl, .sts,
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_val(cfg_ch.data),
    .i_removed(in_ch.frag_removed), .i_start(in_ch.frag_start),
    .i_speed(in_ch.frag_speed), .i_last(in_ch.frag_last),
    .i_src(in_ch.query_source_time), .i_out(in_ch.query_output_time),
    .o_fvalid(out_ch.forward_valid), .o_ftime(out_ch.forward_time),
    .o_atime(out_ch.forward_after_time), .o_btime(out_ch.backward_time)
  );
endmodule
`default_nettype wire

@@ hw/rtl/etrt_checker.sv @@
`default_nettype none
module etrt_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_fv,
  input wire logic [39:0] out_ft
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input taken with result pending");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fv) |-> out_ft == 40'd0) else $error("invalid forward nonzero");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
endmodule

bind edit_time_remap_table etrt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_fv(out_ch.forward_valid), .out_ft(out_ch.forward_time)
);
`default_nettype wire

@@ tb/etrt_remap_checker.sv @@
`timescale 1ns / 100ps
module etrt_remap_checker
  import etrt_pkg::*;
#(
  parameter int MAX_PIECES = 64
) (
  input  logic clk,
  input  logic rst_n,
  etrt_in_if   in_mon,
  etrt_out_if  out_mon,
  etrt_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);

  typedef struct packed {
    logic          fv;
    logic [TW-1:0] ft;
    logic [TW-1:0] fa;
    logic [TW-1:0] bt;
  } remap_t;

  remap_t expected_q[$];

  logic [TW-1:0] dur_r, tin_r, tout_r;
  logic [TW-1:0] pc_src_start[MAX_PIECES];
  logic [TW-1:0] pc_src_end[MAX_PIECES];
  logic [TW-1:0] pc_out_start[MAX_PIECES];
  logic [RW-1:0] pc_rate[MAX_PIECES];
  int            pc_count;
  logic [TW-1:0] out_end;
  logic [TW-1:0] held_start;
  logic          held_removed;
  logic [RW-1:0] held_rate;
  logic          held_valid;

  function automatic logic [TW-1:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > TMAX) ? TMAX : s[TW-1:0];
  endfunction

  function automatic logic [63:0] stretch(logic [TW-1:0] delta, logic [RW-1:0] rate);
    logic [63:0] r;
    r = (rate == 0) ? 64'd1 : {48'd0, rate};
    return ({24'd0, delta} << 8) / r;
  endfunction

  function automatic void add_piece(logic [TW-1:0] from, logic [TW-1:0] to,
                                    logic removed, logic [RW-1:0] rate);
    logic [TW-1:0] lo, hi, s, e;
    lo = (tin_r < dur_r) ? tin_r : dur_r;
    hi = (tout_r < lo) ? lo : ((tout_r > dur_r) ? dur_r : tout_r);
    s  = (from > lo) ? from : lo;
    e  = (to < hi) ? to : hi;
    if (removed || e <= s || pc_count >= MAX_PIECES) return;
    pc_src_start[pc_count] = s;
    pc_src_end[pc_count]   = e;
    pc_out_start[pc_count] = out_end;
    pc_rate[pc_count]      = (rate == 0) ? 16'd1 : rate;
    pc_count++;
    out_end = sat_add(out_end, stretch(e - s, rate));
  endfunction

  function automatic remap_t map_query(logic [TW-1:0] src, logic [TW-1:0] q);
    remap_t r;
    logic   found;
    logic [TW-1:0] t, dt;
    logic [63:0] v;
    int k;
    r = '0;
    r.fa = out_end;
    for (int i = 0; i < pc_count; i++) begin
      if (src >= pc_src_start[i] && (src < pc_src_end[i] ||
          (i + 1 == pc_count && src == pc_src_end[i]))) begin
        r.fv = 1'b1;
        r.ft = sat_add(pc_out_start[i], stretch(src - pc_src_start[i], pc_rate[i]));
        break;
      end
    end
    found = 1'b0;
    for (int i = 0; i < pc_count && !found; i++) begin
      if (src < pc_src_start[i]) begin
        r.fa = pc_out_start[i];
        found = 1'b1;
      end else if (src < pc_src_end[i]) begin
        r.fa = sat_add(pc_out_start[i], stretch(src - pc_src_start[i], pc_rate[i]));
        found = 1'b1;
      end
    end
    if (pc_count > 0) begin
      t = (q < out_end) ? q : out_end;
      k = 0;
      for (int i = 0; i < pc_count; i++) begin
        if (pc_out_start[i] <= t) k = i;
        else break;
      end
      dt = (t >= pc_out_start[k]) ? t - pc_out_start[k] : '0;
      v = {24'd0, pc_src_start[k]} + (({24'd0, dt} * {48'd0, pc_rate[k]}) >> 8);
      r.bt = (v < {24'd0, pc_src_end[k]}) ? v[TW-1:0] : pc_src_end[k];
    end
    return r;
  endfunction

  function automatic void load_fragment(logic [TW-1:0] start, logic removed,
                                        logic [RW-1:0] rate, logic last);
    if (!held_valid) begin
      pc_count = 0;
      out_end  = '0;
    end else begin
      add_piece(held_start, start, held_removed, held_rate);
    end
    if (last) begin
      add_piece(start, dur_r, removed, rate);
      held_valid = 1'b0;
    end else begin
      held_start   = start;
      held_removed = removed;
      held_rate    = rate;
      held_valid   = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    remap_t exp_r;
    if (!rst_n) begin
      expected_q.delete();
      dur_r = '0; tin_r = '0; tout_r = '0;
      pc_count = 0; out_end = '0;
      held_start = '0; held_removed = 1'b0; held_rate = '0; held_valid = 1'b0;
      fail_count <= 0;
      pending_count <= 0;
      result_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("[%0t] unexpected result transaction", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_mon.forward_valid !== exp_r.fv || out_mon.forward_time !== exp_r.ft ||
              out_mon.forward_after_time !== exp_r.fa || out_mon.backward_time !== exp_r.bt)
              begin
            if (fail_count < 10)
              $display("[%0t] mismatch: exp fv=%0b ft=%h fa=%h bt=%h  got fv=%0b ft=%h fa=%h bt=%h",
                       $realtime, exp_r.fv, exp_r.ft, exp_r.fa, exp_r.bt, out_mon.forward_valid,
                       out_mon.forward_time, out_mon.forward_after_time, out_mon.backward_time);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_DUR:  dur_r  = cfg_mon.data;
          REG_TIN:  tin_r  = cfg_mon.data;
          REG_TOUT: tout_r = cfg_mon.data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_LOAD)
          load_fragment(in_mon.frag_start, in_mon.frag_removed, in_mon.frag_speed,
                        in_mon.frag_last);
        else
          expected_q.push_back(map_query(in_mon.query_source_time, in_mon.query_output_time));
      end
      pending_count <= expected_q.size();
    end
  end

endmodule

@@ tb/tb_edit_time_remap_table.sv @@
`timescale 1ns / 100ps
module tb_edit_time_remap_table;
  import etrt_pkg::*;

  localparam int  CYCLE_LIMIT = 4000000;
  localparam int  DRAIN = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, result_count;
  int   cycles = 0;
  int   items_sent = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  logic [TW-1:0] dur_now;
  logic [TW-1:0] recent_starts[$];

  etrt_in_if  in_ch();
  etrt_out_if out_ch();
  etrt_cfg_if cfg_ch();

  edit_time_remap_table dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  etrt_remap_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("edit_time_remap_table verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (recv_stall > 0) out_ch.ready <= ($urandom_range(99) >= recv_stall);
    else out_ch.ready <= 1'b1;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.command = CMD_LOAD; in_ch.frag_start = '0;
    in_ch.frag_removed = 1'b0; in_ch.frag_speed = '0; in_ch.frag_last = 1'b0;
    in_ch.query_source_time = '0; in_ch.query_output_time = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_DUR; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [TW-1:0] rand40();
    return TW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [TW-1:0] rand_upto(logic [TW-1:0] lim);
    logic [63:0] m;
    m = {24'd0, lim} + 64'd1;
    return TW'({$urandom(), $urandom()} % m);
  endfunction

  function automatic logic [RW-1:0] pick_speed();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'h0100;
      default: return RW'($urandom());
    endcase
  endfunction

  task automatic send(logic cmd, logic [TW-1:0] start, logic rem, logic [RW-1:0] spd,
                      logic last, logic [TW-1:0] qs, logic [TW-1:0] qo);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.frag_start <= start;
    in_ch.frag_removed <= rem;
    in_ch.frag_speed <= spd;
    in_ch.frag_last <= last;
    in_ch.query_source_time <= qs;
    in_ch.query_output_time <= qo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load(logic [TW-1:0] start, logic rem, logic [RW-1:0] spd, logic last);
    send(CMD_LOAD, start, rem, spd, last, rand40(), rand40());
  endtask

  task automatic query(logic [TW-1:0] qs, logic [TW-1:0] qo);
    send(CMD_QUERY, rand40(), 1'($urandom()), RW'($urandom()), 1'($urandom()), qs, qo);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [TW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic configure(logic [TW-1:0] d, logic [TW-1:0] ti, logic [TW-1:0] to);
    write_reg(REG_DUR, d);
    write_reg(REG_TIN, ti);
    write_reg(REG_TOUT, to);
    cfg_ch.valid <= 1'b0;
    dur_now = d;
  endtask

  task automatic random_query();
    logic [TW-1:0] qs, qo, b;
    b = (recent_starts.size() > 0) ?
        recent_starts[$urandom_range(recent_starts.size() - 1)] : '0;
    case ($urandom_range(9))
      0, 1, 2, 3: qs = b + TW'($urandom_range(2)) - TW'(1);
      4:          qs = dur_now;
      5, 6, 7:    qs = rand_upto(dur_now);
      default:    qs = rand40();
    endcase
    case ($urandom_range(9))
      0, 1, 2: qo = TW'($urandom_range(1 << 20));
      3, 4, 5: qo = rand40();
      6:       qo = TMAX;
      default: qo = b << $urandom_range(8);
    endcase
    query(qs, qo);
  endtask

  task automatic random_build();
    logic [TW-1:0] st[$];
    int n;
    logic unordered;
    n = ($urandom_range(99) < 3) ? $urandom_range(66, 70) : $urandom_range(1, 8);
    unordered = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) st.push_back(rand_upto(dur_now));
    if (!unordered) st.sort();
    recent_starts = st;
    for (int i = 0; i < n; i++) begin
      load(st[i], $urandom_range(3) == 0, pick_speed(), i == n - 1);
      if ($urandom_range(99) < 5) random_query();
    end
    repeat ($urandom_range(1, 6)) random_query();
  endtask

  task automatic noise();
    if ($urandom_range(1)) load(rand40(), 1'($urandom()), RW'($urandom()), 1'($urandom()));
    else query(rand40(), rand40());
  endtask

  task automatic run_phase(int idle, int stall, int quota);
    int target;
    send_idle = idle;
    recv_stall = stall;
    target = items_sent + quota;
    while (items_sent < target) begin
      if ($urandom_range(9) == 0) noise();
      else random_build();
    end
    settle();
  endtask

  localparam logic [TW-1:0] D0 = 40'd256000;

  initial begin
    logic [TW-1:0] d;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure(D0, '0, TMAX);
    dur_now = D0;
    query(40'd5, 40'd5);
    load(40'd0, 1'b0, 16'h0100, 1'b0);
    load(40'd1000, 1'b1, 16'h0100, 1'b0);
    load(40'd2000, 1'b0, 16'h0000, 1'b0);
    load(40'd2500, 1'b0, 16'hFFFF, 1'b1);
    query(40'd0, 40'd0);
    query(40'd1500, 40'd1000);
    query(D0, TMAX);
    query(40'd2500, 40'd1000 + 40'd500 * 40'd65536);
    query(TMAX, 40'd999);
    load(40'd5000, 1'b0, 16'h0200, 1'b0);
    load(40'd100, 1'b0, 16'h0080, 1'b1);
    query(40'd5000, 40'd10);
    load(40'd0, 1'b0, 16'hFFFF, 1'b1);
    query(40'd12345, 40'd77);
    load(40'd10, 1'b0, 16'h0100, 1'b0);
    query(40'd15, 40'd3);
    load(40'd20, 1'b0, 16'h0100, 1'b1);
    query(40'd15, 40'd3);
    settle();

    configure(TMAX, '0, TMAX);
    run_phase(0, 0, 370);
    d = TW'($urandom_range(1, 1 << 24));
    configure(d, d >> 2, d - (d >> 2));
    run_phase(57, 0, 370);
    d = {8'd0, $urandom()};
    configure(d, d + 40'd5, '0);
    run_phase(0, 57, 370);
    d = rand40();
    configure(d, rand_upto(d), rand40());
    run_phase(18, 18, 370);
    configure('0, TMAX, TMAX);
    run_phase(0, 0, 30);

    $display("%0d input transactions and %0d query results checked over 6 register settings",
             items_sent, result_count);
    $display("idling mixes: none, sender 57%%, receiver 57%%, both 18%%; mismatches %0d",
             fail_count);
    if (fail_count == 0) $display("edit_time_remap_table verification clean");
    else $display("edit_time_remap_table verification failed");
    $finish;
  end

endmodule
